>>> src/ffca_pkg.sv
// Package for the first-fit coalescing allocator.
// Holds sizes, opcodes, status codes and the sequencer state type.
// No dependencies.
package ffca_pkg;

  localparam int MaxSegments = 16;
  localparam int HeaderBytes = 8;
  localparam int AddrBits    = 32;
  localparam int IdxBits     = $clog2(MaxSegments);
  localparam int CntBits     = $clog2(MaxSegments + 1);

  typedef logic [AddrBits-1:0] addr_t;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REGION = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FAIL = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,      // read entry idx
    S_EVAL,      // data of entry idx is valid
    S_NEXT,      // read entry idx+1 (merge with next)
    S_NEXT_EVAL,
    S_PREV,      // read entry idx-1 (merge with previous)
    S_PREV_EVAL,
    S_SHIFT_RD,  // move entries: read source
    S_SHIFT_WR,  // move entries: write destination
    S_OUT
  } state_t;

endpackage

>>> src/first_fit_coalescing_allocator.sv
// First-fit, address-ordered free-segment allocator with coalescing.
// Uses ffca_pkg; holds the segment table in a small memory inside the module.
//
// Usage:
//   s_axis carries one request: tdata = {length, address}, tuser = opcode.
//   m_axis carries one result: tdata = {free_count, header_value, user_address},
//   tuser = status.
//   Every request gives exactly one result.
// Sequencing:
//   One request at a time. A request walks the segment table entry by entry,
//   with a memory read and then a compare for each entry, and insert or remove
//   moves the following entries with a read and then a write for each entry.
//   s_axis_tready is high only while the sequencer is idle.
// Reset:
//   rst clears the segment count; table contents are undefined until written.
// Stall:
//   The result is held in an output register until m_axis_tready; the next
//   request is taken in the cycle after the result leaves.
module first_fit_coalescing_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // address[31:0], length[63:32]
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // user_address[31:0], header_value[63:32],
                                      // free_count[68:64]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int IW = ffca_pkg::IdxBits;
  localparam int CW = ffca_pkg::CntBits;
  localparam int AW = ffca_pkg::AddrBits;

  // segment table: {len, start}
  logic [2*AW-1:0] mem [ffca_pkg::MaxSegments];
  logic [2*AW-1:0] rd_data;
  logic            wr_en;
  logic [IW-1:0]   wr_idx, rd_idx;
  logic [2*AW-1:0] wr_data;

  ffca_pkg::state_t state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    idx, idx_next;          // current entry
  logic [CW-1:0]    mv, mv_next;            // shift cursor
  logic             mv_up, mv_up_next;      // 1: insert (move up), 0: remove
  ffca_pkg::opcode_t op;
  ffca_pkg::addr_t  a, s;                   // request block / alloc total
  ffca_pkg::addr_t  a_next, s_next;
  ffca_pkg::addr_t  cur_start, cur_len;     // entry held for merge
  ffca_pkg::addr_t  cur_start_next, cur_len_next;
  logic [2*AW-1:0]  ins, ins_next;          // entry written at end of insert
  ffca_pkg::status_t res_st, res_st_next;
  ffca_pkg::addr_t  res_ua, res_ua_next, res_hv, res_hv_next;

  ffca_pkg::addr_t  rd_start, rd_len, rd_end, blk_end;
  logic [AW:0]      tot_wide;

  assign rd_start = rd_data[AW-1:0];
  assign rd_len   = rd_data[2*AW-1:AW];
  assign rd_end   = rd_start + rd_len;
  assign blk_end  = a + s;
  assign tot_wide = {1'b0, s_axis_tdata[63:32]} + (AW+1)'(ffca_pkg::HeaderBytes);

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    rd_data <= mem[rd_idx];
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffca_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx <= idx_next; mv <= mv_next; mv_up <= mv_up_next;
    a <= a_next; s <= s_next; cur_start <= cur_start_next; cur_len <= cur_len_next;
    ins <= ins_next;
    res_st <= res_st_next; res_ua <= res_ua_next; res_hv <= res_hv_next;
    if (state == ffca_pkg::S_IDLE && s_axis_tvalid)
      op <= ffca_pkg::opcode_t'(s_axis_tuser);
  end

  // sequencer
  always_comb begin
    state_next = state; count_next = count; idx_next = idx; mv_next = mv;
    mv_up_next = mv_up; a_next = a; s_next = s; cur_start_next = cur_start;
    cur_len_next = cur_len; ins_next = ins;
    res_st_next = res_st; res_ua_next = res_ua;
    res_hv_next = res_hv;
    wr_en = 1'b0; wr_idx = idx[IW-1:0]; wr_data = '0; rd_idx = idx[IW-1:0];
    unique case (state)
      ffca_pkg::S_IDLE: begin
        idx_next = '0;
        res_st_next = ffca_pkg::ST_FAIL; res_ua_next = '0; res_hv_next = '0;
        a_next = s_axis_tdata[31:0];
        s_next = s_axis_tdata[63:32];
        if (s_axis_tvalid) begin
          unique case (ffca_pkg::opcode_t'(s_axis_tuser))
            ffca_pkg::OP_ALLOC: begin
              s_next = tot_wide[AW-1:0];
              state_next = tot_wide[AW] ? ffca_pkg::S_OUT : ffca_pkg::S_SCAN;
            end
            ffca_pkg::OP_FREE: begin
              a_next = s_axis_tdata[31:0] - AW'(ffca_pkg::HeaderBytes);
              state_next = ffca_pkg::S_SCAN;
            end
            ffca_pkg::OP_REGION: state_next = ffca_pkg::S_SCAN;
            default: state_next = ffca_pkg::S_OUT;
          endcase
        end
      end
      ffca_pkg::S_SCAN: begin
        if (idx >= count) begin
          if (op == ffca_pkg::OP_ALLOC) state_next = ffca_pkg::S_OUT;
          else if (count >= CW'(ffca_pkg::MaxSegments)) begin
            res_st_next = ffca_pkg::ST_FULL; state_next = ffca_pkg::S_OUT;
          end else begin
            // append at end
            wr_en = 1'b1; wr_idx = idx[IW-1:0]; wr_data = {s, a};
            count_next = count + 1'b1; res_st_next = ffca_pkg::ST_DONE;
            state_next = ffca_pkg::S_OUT;
          end
        end else state_next = ffca_pkg::S_EVAL;
      end
      ffca_pkg::S_EVAL: begin
        cur_start_next = rd_start; cur_len_next = rd_len;
        if (op == ffca_pkg::OP_ALLOC) begin
          if (rd_len >= s) begin
            res_st_next = ffca_pkg::ST_DONE; res_hv_next = s;
            res_ua_next = rd_start + AW'(ffca_pkg::HeaderBytes);
            if (rd_len > s) begin
              wr_en = 1'b1; wr_data = {rd_len - s, rd_start + s};
              state_next = ffca_pkg::S_OUT;
            end else begin
              mv_next = idx; mv_up_next = 1'b0; count_next = count - 1'b1;
              state_next = ffca_pkg::S_SHIFT_RD;
            end
          end else begin
            idx_next = idx + 1'b1; state_next = ffca_pkg::S_SCAN;
          end
        end else if (rd_start < a) begin
          if (rd_end == a) begin
            cur_len_next = rd_len + s;
            wr_en = 1'b1; wr_data = {rd_len + s, rd_start};
            res_st_next = ffca_pkg::ST_DONE;
            state_next = ffca_pkg::S_NEXT;
          end else begin
            idx_next = idx + 1'b1; state_next = ffca_pkg::S_SCAN;
          end
        end else if (blk_end == rd_start) begin
          cur_start_next = a; cur_len_next = rd_len + s;
          wr_en = 1'b1; wr_data = {rd_len + s, a};
          res_st_next = ffca_pkg::ST_DONE;
          state_next = (idx != '0) ? ffca_pkg::S_PREV : ffca_pkg::S_OUT;
        end else if (count >= CW'(ffca_pkg::MaxSegments)) begin
          res_st_next = ffca_pkg::ST_FULL; state_next = ffca_pkg::S_OUT;
        end else begin
          // insert at idx: move idx..count-1 up by one
          res_st_next = ffca_pkg::ST_DONE; ins_next = {s, a};
          mv_next = count; mv_up_next = 1'b1; count_next = count + 1'b1;
          state_next = ffca_pkg::S_SHIFT_RD;
        end
      end
      ffca_pkg::S_NEXT: begin
        rd_idx = IW'(idx + 1'b1);
        state_next = (idx + 1'b1 < count) ? ffca_pkg::S_NEXT_EVAL : ffca_pkg::S_OUT;
      end
      ffca_pkg::S_NEXT_EVAL: begin
        if (cur_start + cur_len == rd_start) begin
          wr_en = 1'b1; wr_idx = IW'(idx + 1'b1);
          wr_data = {rd_len + cur_len, cur_start};
          mv_next = idx; mv_up_next = 1'b0; count_next = count - 1'b1;
          state_next = ffca_pkg::S_SHIFT_RD;
        end else state_next = ffca_pkg::S_OUT;
      end
      ffca_pkg::S_PREV: begin
        rd_idx = IW'(idx - 1'b1); state_next = ffca_pkg::S_PREV_EVAL;
      end
      ffca_pkg::S_PREV_EVAL: begin
        if (rd_end == cur_start) begin
          wr_en = 1'b1; wr_idx = IW'(idx - 1'b1);
          wr_data = {rd_len + cur_len, rd_start};
          mv_next = idx; mv_up_next = 1'b0; count_next = count - 1'b1;
          state_next = ffca_pkg::S_SHIFT_RD;
        end else state_next = ffca_pkg::S_OUT;
      end
      ffca_pkg::S_SHIFT_RD: begin
        // count already updated; remove: move mv+1 -> mv while mv < count
        // insert: move mv-1 -> mv while mv > idx
        if (mv_up) begin
          if (mv > idx) begin
            rd_idx = IW'(mv - 1'b1); state_next = ffca_pkg::S_SHIFT_WR;
          end else begin
            wr_en = 1'b1; wr_idx = idx[IW-1:0]; wr_data = ins;
            state_next = ffca_pkg::S_OUT;
          end
        end else if (mv < count) begin
          rd_idx = IW'(mv + 1'b1); state_next = ffca_pkg::S_SHIFT_WR;
        end else state_next = ffca_pkg::S_OUT;
      end
      ffca_pkg::S_SHIFT_WR: begin
        wr_en = 1'b1; wr_idx = mv[IW-1:0]; wr_data = rd_data;
        mv_next = mv_up ? mv - 1'b1 : mv + 1'b1;
        state_next = ffca_pkg::S_SHIFT_RD;
      end
      ffca_pkg::S_OUT: begin
        if (m_axis_tready) state_next = ffca_pkg::S_IDLE;
      end
      default: state_next = ffca_pkg::S_IDLE;
    endcase
  end

  // handshake and result
  always_comb begin
    s_axis_tready = (state == ffca_pkg::S_IDLE);
    m_axis_tvalid = (state == ffca_pkg::S_OUT);
    m_axis_tdata  = {3'b000, count, res_hv, res_ua};
    m_axis_tuser  = res_st;
  end

endmodule

>>> test/tb_top.sv
// Testbench for first_fit_coalescing_allocator: random and directed requests
// checked against an in-bench model of the address-ordered free-segment table.
// Depends on ffca_pkg and the allocator RTL.
module tb_top;

  typedef struct packed {
    ffca_pkg::opcode_t op;
    ffca_pkg::addr_t   address;
    ffca_pkg::addr_t   length;
  } alloc_req_t;

  typedef struct packed {
    ffca_pkg::status_t            status;
    ffca_pkg::addr_t              user_address;
    ffca_pkg::addr_t              header_value;
    logic [ffca_pkg::CntBits-1:0] free_count;
  } alloc_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  first_fit_coalescing_allocator DUT (.*);

  always #2 clk = ~clk;

  // Model of the free-segment table
  ffca_pkg::addr_t seg_start [ffca_pkg::MaxSegments];
  ffca_pkg::addr_t seg_len   [ffca_pkg::MaxSegments];
  int    seg_cnt = 0;

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  int         mismatches = 0;
  int         send_idle = 13;
  int         recv_idle = 87;
  bit         in_acc = 1'b0;   // request taken at the last rising edge

  function automatic void drop_seg(int i);
    for (int k = i; k + 1 < seg_cnt; k++) begin
      seg_start[k] = seg_start[k+1];
      seg_len[k]   = seg_len[k+1];
    end
    seg_cnt--;
  endfunction

  function automatic ffca_pkg::status_t put_seg(int i, ffca_pkg::addr_t a,
                                                ffca_pkg::addr_t s);
    if (seg_cnt >= ffca_pkg::MaxSegments) return ffca_pkg::ST_FULL;
    for (int k = seg_cnt; k > i; k--) begin
      seg_start[k] = seg_start[k-1];
      seg_len[k]   = seg_len[k-1];
    end
    seg_start[i] = a;
    seg_len[i]   = s;
    seg_cnt++;
    return ffca_pkg::ST_DONE;
  endfunction

  // Insert a block in address order, merging with touching neighbors
  function automatic ffca_pkg::status_t return_block(ffca_pkg::addr_t a,
                                                     ffca_pkg::addr_t s);
    for (int i = 0; i < seg_cnt; i++) begin
      if (seg_start[i] < a) begin
        if (ffca_pkg::addr_t'(seg_start[i] + seg_len[i]) == a) begin
          seg_len[i] += s;
          if (i + 1 < seg_cnt &&
              ffca_pkg::addr_t'(seg_start[i] + seg_len[i]) == seg_start[i+1]) begin
            seg_start[i+1] = seg_start[i];
            seg_len[i+1]   = seg_len[i+1] + seg_len[i];
            drop_seg(i);
          end
          return ffca_pkg::ST_DONE;
        end
      end else begin
        if (ffca_pkg::addr_t'(a + s) == seg_start[i]) begin
          seg_start[i] = a;
          seg_len[i]  += s;
          if (i > 0 &&
              ffca_pkg::addr_t'(seg_start[i-1] + seg_len[i-1]) == seg_start[i]) begin
            seg_len[i-1] += seg_len[i];
            drop_seg(i);
          end
          return ffca_pkg::ST_DONE;
        end
        return put_seg(i, a, s);
      end
    end
    return put_seg(seg_cnt, a, s);
  endfunction

  function automatic alloc_rsp_t predict_alloc(alloc_req_t r);
    alloc_rsp_t p;
    ffca_pkg::addr_t total;
    p = '{ffca_pkg::ST_FAIL, '0, '0, '0};
    case (r.op)
      ffca_pkg::OP_ALLOC: begin
        total = r.length + ffca_pkg::addr_t'(ffca_pkg::HeaderBytes);
        if (total >= r.length) begin
          for (int i = 0; i < seg_cnt; i++) begin
            if (seg_len[i] >= total) begin
              p.user_address = seg_start[i] + ffca_pkg::addr_t'(ffca_pkg::HeaderBytes);
              p.header_value = total;
              p.status = ffca_pkg::ST_DONE;
              if (seg_len[i] > total) begin
                seg_start[i] += total;
                seg_len[i]   -= total;
              end else begin
                drop_seg(i);
              end
              break;
            end
          end
        end
      end
      ffca_pkg::OP_FREE:
        p.status = return_block(r.address - ffca_pkg::addr_t'(ffca_pkg::HeaderBytes),
                                r.length);
      ffca_pkg::OP_REGION: p.status = return_block(r.address, r.length);
      default:   p.status = ffca_pkg::ST_FAIL;
    endcase
    p.free_count = seg_cnt[ffca_pkg::CntBits-1:0];
    return p;
  endfunction

  // Request driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || in_acc) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
          alloc_req_t r;
          r = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {r.length, r.address};
          s_axis_tuser  <= r.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Request/result monitor
  always @(posedge clk) begin
    in_acc = s_axis_tvalid && s_axis_tready && !rst;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        alloc_req_t r;
        r.op = ffca_pkg::opcode_t'(s_axis_tuser);
        r.address = s_axis_tdata[31:0];
        r.length  = s_axis_tdata[63:32];
        expected_rsps.push_back(predict_alloc(r));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        alloc_rsp_t e;
        alloc_rsp_t a;
        a.status = ffca_pkg::status_t'(m_axis_tuser[1:0]);
        a.free_count = m_axis_tdata[68:64];
        a.user_address = m_axis_tdata[31:0];
        a.header_value = m_axis_tdata[63:32];
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", a);
        end else begin
          e = expected_rsps.pop_front();
          if (a.status !== e.status || a.user_address !== e.user_address ||
              a.header_value !== e.header_value || a.free_count !== e.free_count) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, a);
          end
        end
      end
    end
  end

  function automatic void add_req(ffca_pkg::opcode_t op, ffca_pkg::addr_t a,
                                  ffca_pkg::addr_t l);
    alloc_req_t r;
    r.op = op;
    r.address = a;
    r.length = l;
    pending_reqs.push_back(r);
  endfunction

  // Stimulus
  initial begin
    ffca_pkg::addr_t base;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty-table cases, merges, wrap, full table, overflow
    add_req(ffca_pkg::OP_ALLOC, 32'h0, 32'h10);
    add_req(ffca_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(ffca_pkg::OP_REGION, 32'h1000, 32'h100);
    add_req(ffca_pkg::OP_ALLOC, 32'h0, 32'hFFFF_FFF8);
    add_req(ffca_pkg::OP_ALLOC, 32'h0, 32'hFFFF_FFFF);
    add_req(ffca_pkg::OP_ALLOC, 32'h0, 32'h0);
    add_req(ffca_pkg::OP_ALLOC, 32'h0, 32'hF0);
    add_req(ffca_pkg::OP_REGION, 32'h2000, 32'h0);
    add_req(ffca_pkg::OP_REGION, 32'h2000, 32'h10);
    add_req(ffca_pkg::OP_REGION, 32'h1F00, 32'h100);
    add_req(ffca_pkg::OP_FREE, 32'h1008, 32'h8);
    add_req(ffca_pkg::OP_REGION, 32'hFFFF_FF00, 32'h100);
    add_req(ffca_pkg::OP_REGION, 32'h0, 32'h20);
    add_req(ffca_pkg::OP_ALLOC, 32'h0, 32'h300);
    for (int i = 0; i < 17; i++)
      add_req(ffca_pkg::OP_REGION, 32'h10_0000 + i * 32'h100, 32'h40);
    add_req(ffca_pkg::OP_ALLOC, 32'h0, 32'h38);

    // Random: mostly allocate/free traffic in a small arena
    base = 32'h4000_0000;
    for (int n = 0; n < 450; n++) begin
      int k;
      k = $urandom_range(99);
      if (n == 150) begin send_idle = 87; recv_idle = 13; end
      if (n == 300) begin send_idle = 0;  recv_idle = 0;  end
      if (k < 35)
        add_req(ffca_pkg::OP_ALLOC, $urandom, $urandom_range(64));
      else if (k < 65)
        add_req(ffca_pkg::OP_FREE, base + 8 * $urandom_range(256), 8 * $urandom_range(8));
      else if (k < 85)
        add_req(ffca_pkg::OP_REGION, base + 8 * $urandom_range(256),
                8 * $urandom_range(16));
      else if (k < 92)
        add_req(ffca_pkg::opcode_t'($urandom_range(3)), $urandom, $urandom);
      else
        add_req(ffca_pkg::OP_ALLOC, $urandom, $urandom);
      // Keep the driver fed but let the idle setting apply to each third
      while (pending_reqs.size() > 8) @(posedge clk);
    end
    while (pending_reqs.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (expected_rsps.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

>>> sim.f
src/ffca_pkg.sv
src/first_fit_coalescing_allocator.sv
test/tb_top.sv
